FILE: design/radix_integer_to_text_macros.svh
// Assertion macros shared by the radix_integer_to_text RTL.
// Depends on a clock i_clk and a synchronous active-low reset i_rst_n in scope.
`ifndef RADIX_INTEGER_TO_TEXT_MACROS_SVH
`define RADIX_INTEGER_TO_TEXT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RIT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RIT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rit_pkg.sv
// Package for radix_integer_to_text: fixed widths, codes, command/status structs,
// character class and reciprocal table functions. No dependencies.
package rit_pkg;

    localparam int IN_W      = 32;   // input number field
    localparam int SYM_W     = 8;    // output symbol byte
    localparam int BASE_W    = 5;    // base_size register
    localparam int CFG_DW    = 64;   // configuration data width
    localparam int CFG_AW    = 5;    // configuration byte address width
    localparam int ALPHA_N   = 16;   // symbols held by the two alphabet registers
    localparam int ALPHA_W   = ALPHA_N * SYM_W;
    localparam int RECIP_W   = 32;   // reciprocal scale is 2^RECIP_W

    localparam logic [SYM_W-1:0] MINUS_SYM = 8'h2D;
    localparam logic [SYM_W-1:0] CH_0      = 8'h30;
    localparam logic [SYM_W-1:0] CH_9      = 8'h39;
    localparam logic [SYM_W-1:0] CH_LA     = 8'h61;
    localparam logic [SYM_W-1:0] CH_LZ     = 8'h7A;
    localparam logic [SYM_W-1:0] CH_UA     = 8'h41;
    localparam logic [SYM_W-1:0] CH_UZ     = 8'h5A;

    // Register indexes (byte address bits [4:3])
    localparam logic [1:0] REG_ALPHA_LO = 2'd0;
    localparam logic [1:0] REG_ALPHA_HI = 2'd1;
    localparam logic [1:0] REG_BASE     = 2'd2;

    typedef struct packed {
        logic load;        // capture magnitude and sign of a new number
        logic mul;         // register reciprocal product
        logic fix;         // correct quotient, store digit
        logic rd;          // read next digit from the store
        logic emit_sign;   // load minus sign into output register
        logic emit_digit;  // load digit symbol into output register
        logic emit_inval;  // load the invalid-alphabet result
    } t_rit_cmd;

    typedef struct packed {
        logic alpha_ok;    // alphabet passes validation
        logic neg;         // current number is negative
        logic q_zero;      // corrected quotient is zero
        logic cnt_zero;    // no digits left in the store
        logic out_free;    // output register can take a symbol
    } t_rit_sts;

    function automatic logic is_alnum(input logic [SYM_W-1:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
               (c >= CH_UA && c <= CH_UZ);
    endfunction

    // floor(2^32 / b); quotient estimate is low by at most one
    function automatic logic [RECIP_W-1:0] recip(input logic [BASE_W-1:0] b);
        logic [RECIP_W-1:0] r;
        case (b)
            5'd2:    r = RECIP_W'(33'h1_0000_0000 / 2);
            5'd3:    r = RECIP_W'(33'h1_0000_0000 / 3);
            5'd4:    r = RECIP_W'(33'h1_0000_0000 / 4);
            5'd5:    r = RECIP_W'(33'h1_0000_0000 / 5);
            5'd6:    r = RECIP_W'(33'h1_0000_0000 / 6);
            5'd7:    r = RECIP_W'(33'h1_0000_0000 / 7);
            5'd8:    r = RECIP_W'(33'h1_0000_0000 / 8);
            5'd9:    r = RECIP_W'(33'h1_0000_0000 / 9);
            5'd10:   r = RECIP_W'(33'h1_0000_0000 / 10);
            5'd11:   r = RECIP_W'(33'h1_0000_0000 / 11);
            5'd12:   r = RECIP_W'(33'h1_0000_0000 / 12);
            5'd13:   r = RECIP_W'(33'h1_0000_0000 / 13);
            5'd14:   r = RECIP_W'(33'h1_0000_0000 / 14);
            5'd15:   r = RECIP_W'(33'h1_0000_0000 / 15);
            5'd16:   r = RECIP_W'(33'h1_0000_0000 / 16);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/rit_ctrl.sv
// Controller for radix_integer_to_text: one-hot sequencer for divide and emit phases.
// Depends on rit_pkg and radix_integer_to_text_macros.svh.
`include "radix_integer_to_text_macros.svh"

module rit_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  rit_pkg::t_rit_sts i_sts,
    output rit_pkg::t_rit_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_FIX   = 7'b0000100,
        S_SIGN  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_INVAL = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.alpha_ok ? S_MUL : S_INVAL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                if (i_sts.q_zero) begin
                    n_state = i_sts.neg ? S_SIGN : S_READ;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    // overlap the next read with this symbol's transfer
                    if (i_sts.cnt_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd = 1'b1;
                    end
                end
            end
            S_INVAL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_inval = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RIT_ASSERT_NXT(a_accept_leaves_idle, in_xfer, r_state != S_IDLE, "idle after accept")
    `RIT_ASSERT_IMP(a_emit_needs_room, o_cmd.emit_sign || o_cmd.emit_digit || o_cmd.emit_inval, i_sts.out_free, "emit into busy output")
    `RIT_ASSERT_IMP(a_read_needs_digit, o_cmd.rd, !i_sts.cnt_zero, "digit read with empty store")

endmodule

FILE: design/rit_dpath.sv
// Datapath for radix_integer_to_text: magnitude, reciprocal divide, digit store,
// alphabet check and output register. Depends on rit_pkg and the macros header.
`include "radix_integer_to_text_macros.svh"

module rit_dpath #(
    parameter int MAX_RADIX    = 16,
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rit_pkg::t_rit_cmd            i_cmd,
    output rit_pkg::t_rit_sts            o_sts,
    input  logic [rit_pkg::IN_W-1:0]     i_number,
    input  logic [rit_pkg::ALPHA_W-1:0]  i_alpha,
    input  logic [rit_pkg::BASE_W-1:0]   i_base,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [rit_pkg::SYM_W-1:0]    o_m_tdata,
    output logic                         o_m_tlast,
    output logic                         o_m_tuser
);

    localparam int NW   = NUMBER_WIDTH;
    localparam int DW   = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int AW   = $clog2(NW);
    localparam int CW   = $clog2(NW + 1);
    localparam int PW   = NW + rit_pkg::RECIP_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(NW);

    logic [rit_pkg::SYM_W-1:0] sym_arr [MAX_RADIX];
    logic [MAX_RADIX-1:0]      sym_ok;
    logic                      alpha_ok;

    logic [NW-1:0]   raw;
    logic [NW-1:0]   abs_val;
    logic [NW-1:0]   r_mag;
    logic            r_neg;
    logic [NW-1:0]   r_q;
    logic [PW-1:0]   prod;
    logic [5:0]      qb_lo;
    logic [5:0]      rem;
    logic            over;
    logic [NW-1:0]   fix_q;
    logic [5:0]      digit6;
    logic [DW-1:0]   digit;

    logic [DW-1:0]   mem [NW];
    logic [DW-1:0]   r_rd_data;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   cnt_dec;

    logic                      r_out_valid;
    logic [rit_pkg::SYM_W-1:0] r_sym;
    logic                      r_last;
    logic                      r_inv;
    logic                      out_free;

    // Alphabet validation: each used symbol alphanumeric and above its predecessor
    always_comb begin
        for (int k = 0; k < MAX_RADIX; k++) begin
            sym_arr[k] = i_alpha[k*rit_pkg::SYM_W +: rit_pkg::SYM_W];
        end
        for (int k = 0; k < MAX_RADIX; k++) begin
            if (rit_pkg::BASE_W'(k) >= i_base) begin
                sym_ok[k] = 1'b1;
            end else if (k == 0) begin
                sym_ok[k] = rit_pkg::is_alnum(sym_arr[k]);
            end else begin
                sym_ok[k] = rit_pkg::is_alnum(sym_arr[k]) && (sym_arr[k-1] < sym_arr[k]);
            end
        end
    end

    assign alpha_ok = (i_base >= rit_pkg::BASE_W'(2)) &&
                      (i_base <= rit_pkg::BASE_W'(MAX_RADIX)) && (&sym_ok);

    // Magnitude as unsigned, so the most negative value maps to 2^(NW-1)
    assign raw     = i_number[NW-1:0];
    assign abs_val = raw[NW-1] ? (~raw + 1'b1) : raw;

    // Quotient estimate by reciprocal, then one correction step.
    // True remainder stays below 2*base <= 32, so six low bits suffice.
    assign prod   = PW'(r_mag) * PW'(rit_pkg::recip(i_base));
    assign qb_lo  = 6'(r_q[5:0] * 6'(i_base));
    assign rem    = r_mag[5:0] - qb_lo;
    assign over   = (rem >= 6'(i_base));
    assign fix_q  = over ? (r_q + 1'b1) : r_q;
    assign digit6 = over ? (rem - 6'(i_base)) : rem;
    assign digit  = digit6[DW-1:0];

    assign cnt_dec = r_cnt - 1'b1;
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= abs_val;
        end else if (i_cmd.fix) begin
            r_mag <= fix_q;
        end
        if (i_cmd.mul) begin
            r_q <= prod[PW-1:rit_pkg::RECIP_W];
        end
    end

    // Digit store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            mem[r_cnt[AW-1:0]] <= digit;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[cnt_dec[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_neg <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
                r_neg <= raw[NW-1];
            end else if (i_cmd.fix) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.rd) begin
                r_cnt <= cnt_dec;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit || i_cmd.emit_inval) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_sym  <= rit_pkg::MINUS_SYM;
            r_last <= 1'b0;
            r_inv  <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_sym  <= sym_arr[r_rd_data];
            r_last <= (r_cnt == '0);
            r_inv  <= 1'b0;
        end else if (i_cmd.emit_inval) begin
            r_sym  <= '0;
            r_last <= 1'b1;
            r_inv  <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_sym;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_inv;

    assign o_sts.alpha_ok = alpha_ok;
    assign o_sts.neg      = r_neg;
    assign o_sts.q_zero   = (fix_q == '0);
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.out_free = out_free;

    `RIT_ASSERT_IMP(a_store_in_range, i_cmd.fix, r_cnt < CNT_MAX, "digit store overflow")
    `RIT_ASSERT_NXT(a_mag_shrinks, i_cmd.fix && r_mag != '0, r_mag < $past(r_mag), "magnitude did not shrink")
    `RIT_ASSERT_IMP(a_digit_below_base, i_cmd.emit_digit, rit_pkg::BASE_W'(r_rd_data) < i_base, "stored digit not below base")

endmodule

FILE: design/radix_integer_to_text.sv
// Sequence: an invalid alphabet goes from the input transfer to S_INVAL, which loads the
// flagged result once the output register is free. Otherwise each digit takes S_MUL and
// S_FIX, then come S_SIGN for a minus sign if present, S_READ, and one symbol per cycle
// (stalls hold it). Numbers are taken one at a time, paced by the shared reciprocal
// multiplier and correction stage and the single read port of the digit store.
// Reset: synchronous active low; clears controller, output valid, digit count, sign flag and the config registers.

module radix_integer_to_text #(
    parameter int MAX_RADIX    = 16,
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [rit_pkg::IN_W-1:0]    i_s_tdata,   // [31:0] number
    // output stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [rit_pkg::SYM_W-1:0]   o_m_tdata,   // [7:0] symbol
    output logic                        o_m_tlast,   // last_symbol
    output logic                        o_m_tuser,   // [0] invalid_base
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rit_pkg::CFG_AW-1:0]  paddr,
    input  logic [rit_pkg::CFG_DW-1:0]  pwdata,
    output logic [rit_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    logic [rit_pkg::CFG_DW-1:0] r_alpha_lo;
    logic [rit_pkg::CFG_DW-1:0] r_alpha_hi;
    logic [rit_pkg::BASE_W-1:0] r_base;
    logic [1:0]                 reg_idx;
    logic                       cfg_wr;

    rit_pkg::t_rit_cmd cmd;
    rit_pkg::t_rit_sts sts;

    // Registers sit on 8-byte strides: index is byte address bits [4:3]
    assign reg_idx = paddr[4:3];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_lo <= '0;
            r_alpha_hi <= '0;
            r_base     <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                rit_pkg::REG_ALPHA_LO: r_alpha_lo <= pwdata;
                rit_pkg::REG_ALPHA_HI: r_alpha_hi <= pwdata;
                rit_pkg::REG_BASE:     r_base     <= pwdata[rit_pkg::BASE_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rit_pkg::REG_ALPHA_LO: prdata = r_alpha_lo;
            rit_pkg::REG_ALPHA_HI: prdata = r_alpha_hi;
            rit_pkg::REG_BASE:     prdata = rit_pkg::CFG_DW'(r_base);
            default:               prdata = '0;
        endcase
    end

    // Sequencer: accept, divide digit by digit, then emit sign and digits MSD first (or flag an invalid alphabet)
    rit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: magnitude register, reciprocal divide, digit store, output register
    rit_dpath #(
        .MAX_RADIX    (MAX_RADIX),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_number   (i_s_tdata),
        .i_alpha    ({r_alpha_hi, r_alpha_lo}),
        .i_base     (r_base),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
